// ===== hdl/ecwd_pkg.sv =====
// Shared types and constants for the event camera word decoder.
package ecwd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 7;
  localparam int unsigned StampW = 16;
  localparam int unsigned TimeW  = 32;

  // Marker bit positions within their bytes
  localparam int unsigned SpecialBit = 7;
  localparam int unsigned WrapBit    = 7;
  localparam int unsigned ResetBit   = 6;

  localparam logic [TimeW-1:0]  WrapStep = 32'h0000_4000;
  localparam logic [CoordW-1:0] CoordMax = 7'd127;

  typedef struct packed {
    logic [ByteW-1:0] addr_low;
    logic [ByteW-1:0] addr_high;
    logic [ByteW-1:0] stamp_low;
    logic [ByteW-1:0] stamp_high;
    logic             last;
  } in_word_t;

endpackage

// ===== hdl/event_camera_word_decoder.sv =====
// Path: input register, one 32-bit add, result register. A word shows its event at the
// outputs from the result register; one word per cycle while out_stall_i is low.
// in_stall_o rises only when the input register is full and the result register
// is full and stalled.
// Reset (rst_ni low, asynchronous) empties both registers and clears wrap offset
// and held time.
module event_camera_word_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ecwd_pkg::ByteW-1:0]    addr_low_byte_i,
  input  logic [ecwd_pkg::ByteW-1:0]    addr_high_byte_i,
  input  logic [ecwd_pkg::ByteW-1:0]    stamp_low_byte_i,
  input  logic [ecwd_pkg::ByteW-1:0]    stamp_high_byte_i,
  input  logic                          last_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          polarity_o,
  output logic [ecwd_pkg::CoordW-1:0]   column_o,
  output logic [ecwd_pkg::CoordW-1:0]   row_o,
  output logic [ecwd_pkg::TimeW-1:0]    event_time_o,
  output logic                          is_special_o,
  output logic                          last_of_buffer_o
);
  import ecwd_pkg::*;

  logic                in_valid_q, in_valid_d;
  in_word_t            in_q;
  logic                out_valid_q, out_valid_d;
  logic                pol_q, pol_d;
  logic [CoordW-1:0]   col_q, col_d;
  logic [CoordW-1:0]   row_q, row_d;
  logic [TimeW-1:0]    time_q, time_d;
  logic                spec_q, spec_d;
  logic                last_q;
  logic [TimeW-1:0]    wrap_offset_q, wrap_offset_d;
  logic [TimeW-1:0]    held_time_q, held_time_d;

  logic                in_load;
  logic                advance;
  logic [StampW-1:0]   stamp;
  logic [TimeW-1:0]    stamp_sum;
  logic                is_spec, is_wrap, is_rst;

  // Result register free to take the word held at the input
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_load || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  assign stamp     = {in_q.stamp_high, in_q.stamp_low};
  assign stamp_sum = {{(TimeW-StampW){1'b0}}, stamp} + wrap_offset_q;
  assign is_spec   = in_q.addr_high[SpecialBit];
  assign is_wrap   = in_q.stamp_high[WrapBit];
  assign is_rst    = in_q.stamp_high[ResetBit];

  always_comb begin
    wrap_offset_d = wrap_offset_q;
    held_time_d   = held_time_q;
    pol_d         = 1'b0;
    col_d         = '0;
    row_d         = '0;
    spec_d        = 1'b1;
    time_d        = stamp_sum;
    if (is_spec) begin
      held_time_d = stamp_sum;
    end else begin
      // wrap wins over reset when both markers are set
      if (is_wrap) begin
        wrap_offset_d = wrap_offset_q + WrapStep;
      end else if (is_rst) begin
        wrap_offset_d = '0;
      end else begin
        held_time_d = stamp_sum;
      end
      time_d = (is_wrap || is_rst) ? held_time_q : stamp_sum;
      pol_d  = ~in_q.addr_low[0];
      col_d  = CoordMax - in_q.addr_high[CoordW-1:0];
      row_d  = CoordMax - in_q.addr_low[ByteW-1:1];
      spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      wrap_offset_q <= '0;
      held_time_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        wrap_offset_q <= wrap_offset_d;
        held_time_q   <= held_time_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q.addr_low   <= addr_low_byte_i;
      in_q.addr_high  <= addr_high_byte_i;
      in_q.stamp_low  <= stamp_low_byte_i;
      in_q.stamp_high <= stamp_high_byte_i;
      in_q.last       <= last_word_i;
    end
    if (advance) begin
      pol_q  <= pol_d;
      col_q  <= col_d;
      row_q  <= row_d;
      time_q <= time_d;
      spec_q <= spec_d;
      last_q <= in_q.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign polarity_o       = pol_q;
  assign column_o         = col_q;
  assign row_o            = row_q;
  assign event_time_o     = time_q;
  assign is_special_o     = spec_q;
  assign last_of_buffer_o = last_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked word");

  a_special_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_spec) |=> (out_valid_o && is_special_o && !polarity_o))
    else $error("special word not flagged at output");

  a_wrap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_spec && is_wrap) |=>
      (wrap_offset_q == $past(wrap_offset_q) + WrapStep))
    else $error("wrap offset did not step");

  a_ctrl_time_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_spec && (is_wrap || is_rst)) |=>
      (event_time_o == $past(held_time_q) && held_time_q == $past(held_time_q)))
    else $error("control word disturbed held time");
`endif

endmodule
